@@ rtl/core/lsta_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsta_pkg
// Shared types and constants for the lottery sum-tree arbiter.
// ----------------------------------------------------------------------------
package lsta_pkg;

    localparam int SUM_W  = 20;
    localparam int ID_W   = 16;
    localparam int TKT_W  = 16;
    localparam int CORE_W = 8;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_MODIFY = 2'd2,
        OP_DRAW   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_BAD_TICKETS = 3'd1,
        ST_ID_EXISTS   = 3'd2,
        ST_FULL        = 3'd3,
        ST_NOT_FOUND   = 3'd4,
        ST_NO_CLIENTS  = 3'd5,
        ST_DRAW_RANGE  = 3'd6
    } t_code;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_UP_RD,
        S_UP_WR,
        S_DN_RD,
        S_DN_STEP,
        S_WIN_RD,
        S_WIN,
        S_OUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic  clr;
        logic  start;
        logic  scan;
        logic  commit;
        logic  up_rd;
        logic  up_wr;
        logic  dn_rd;
        logic  dn_step;
        logic  win_rd;
        logic  win_ld;
        logic  out_ld;
        t_code code;
    } t_ctl;

    // datapath to controller
    typedef struct packed {
        logic clr_done;
        logic scan_done;
        logic found;
        logic free_ok;
        logic tkt_zero;
        logic cnt_zero;
        logic cnt_full;
        logic draw_big;
        logic at_root;
        logic at_leaf;
        logic out_free;
        t_op  op;
    } t_sts;

endpackage

@@ rtl/core/lottery_sum_tree_arbiter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lottery_sum_tree_arbiter
// Lottery arbiter over a binary sum tree of client ticket counts.
// ----------------------------------------------------------------------------
// One command word is handled at a time, and one result word comes out for
// each. With CAP = SLOTS rounded up to a power of two and L = log2(CAP): add,
// remove and modify scan the slot table one entry a cycle, then refresh the
// leaf-to-root sums with a read and then a write per level through the tree
// memory's single read port. A draw walks down the tree with a read and then
// a step per level. Rejected commands skip the walk. After reset a clearing
// pass zeros the tree and slot memories; no command word is taken until it
// ends. A result may wait under stall while the next command word is accepted.
// ----------------------------------------------------------------------------
module lottery_sum_tree_arbiter #(
    parameter int SLOTS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [1:0]                   i_cmd,
    input  logic [lsta_pkg::ID_W-1:0]    i_client_id,
    input  logic [lsta_pkg::TKT_W-1:0]   i_ticket_count,
    input  logic [lsta_pkg::SUM_W-1:0]   i_draw_value,
    input  logic [lsta_pkg::CORE_W-1:0]  i_core_tag,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [2:0]                   o_status,
    output logic [lsta_pkg::ID_W-1:0]    o_winner_id,
    output logic [lsta_pkg::CORE_W-1:0]  o_winner_core,
    output logic [lsta_pkg::SUM_W-1:0]   o_ticket_sum
);
    import lsta_pkg::*;

    t_ctl ctl;
    t_sts sts;

    lsta_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_cmd   (i_cmd),
        .i_sts   (sts),
        .o_ctl   (ctl),
        .o_stall (o_stall)
    );

    lsta_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (ctl),
        .o_sts          (sts),
        .i_cmd          (i_cmd),
        .i_client_id    (i_client_id),
        .i_ticket_count (i_ticket_count),
        .i_draw_value   (i_draw_value),
        .i_core_tag     (i_core_tag),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_winner_id    (o_winner_id),
        .o_winner_core  (o_winner_core),
        .o_ticket_sum   (o_ticket_sum)
    );

endmodule

@@ rtl/core/lsta_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsta_ctrl
// Command sequencer: clear pass, slot scan, tree walk up or down, result.
// ----------------------------------------------------------------------------
module lsta_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [1:0]    i_cmd,
    input  lsta_pkg::t_sts i_sts,
    output lsta_pkg::t_ctl o_ctl,
    output logic          o_stall
);
    import lsta_pkg::*;

    t_state r_state, n_state;
    t_code  r_code, n_code;
    t_code  dec_code;

    // status of the command in hand, in check order
    always_comb begin
        dec_code = ST_OK;
        case (i_sts.op)
            OP_ADD: begin
                if (i_sts.tkt_zero) dec_code = ST_BAD_TICKETS;
                else if (i_sts.found) dec_code = ST_ID_EXISTS;
                else if (i_sts.cnt_full || !i_sts.free_ok) dec_code = ST_FULL;
            end
            OP_REMOVE: begin
                if (!i_sts.found) dec_code = ST_NOT_FOUND;
            end
            OP_MODIFY: begin
                if (i_sts.tkt_zero) dec_code = ST_BAD_TICKETS;
                else if (!i_sts.found) dec_code = ST_NOT_FOUND;
            end
            default: begin
                if (i_sts.cnt_zero) dec_code = ST_NO_CLIENTS;
                else if (i_sts.draw_big) dec_code = ST_DRAW_RANGE;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_code  = r_code;
        case (r_state)
            S_CLEAR:   if (i_sts.clr_done) n_state = S_IDLE;
            S_IDLE: begin
                if (i_valid) n_state = (t_op'(i_cmd) == OP_DRAW) ? S_DECIDE : S_SCAN;
            end
            S_SCAN:    if (i_sts.scan_done) n_state = S_DECIDE;
            S_DECIDE: begin
                n_code = dec_code;
                if (dec_code != ST_OK) n_state = S_OUT;
                else if (i_sts.op == OP_DRAW) n_state = S_DN_RD;
                else n_state = S_UP_RD;
            end
            S_UP_RD:   n_state = i_sts.at_root ? S_OUT : S_UP_WR;
            S_UP_WR:   n_state = S_UP_RD;
            S_DN_RD:   n_state = i_sts.at_leaf ? S_WIN_RD : S_DN_STEP;
            S_DN_STEP: n_state = S_DN_RD;
            S_WIN_RD:  n_state = S_WIN;
            S_WIN:     n_state = S_OUT;
            S_OUT:     if (i_sts.out_free) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ctl         = '0;
        o_ctl.code    = r_code;
        o_stall       = 1'b1;
        case (r_state)
            S_CLEAR:   o_ctl.clr = 1'b1;
            S_IDLE: begin
                o_stall     = 1'b0;
                o_ctl.start = i_valid;
            end
            S_SCAN:    o_ctl.scan = 1'b1;
            S_DECIDE:  o_ctl.commit = (dec_code == ST_OK);
            S_UP_RD:   o_ctl.up_rd = !i_sts.at_root;
            S_UP_WR:   o_ctl.up_wr = 1'b1;
            S_DN_RD:   o_ctl.dn_rd = !i_sts.at_leaf;
            S_DN_STEP: o_ctl.dn_step = 1'b1;
            S_WIN_RD:  o_ctl.win_rd = 1'b1;
            S_WIN:     o_ctl.win_ld = 1'b1;
            S_OUT:     o_ctl.out_ld = i_sts.out_free;
            default:   o_ctl = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_code  <= ST_OK;
        end else begin
            r_state <= n_state;
            r_code  <= n_code;
        end
    end

endmodule

@@ rtl/core/lsta_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsta_dp
// Datapath: sum-tree memory, slot table, walk registers and result register.
// ----------------------------------------------------------------------------
module lsta_dp #(
    parameter int SLOTS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  lsta_pkg::t_ctl               i_ctl,
    output lsta_pkg::t_sts               o_sts,
    input  logic [1:0]                   i_cmd,
    input  logic [lsta_pkg::ID_W-1:0]    i_client_id,
    input  logic [lsta_pkg::TKT_W-1:0]   i_ticket_count,
    input  logic [lsta_pkg::SUM_W-1:0]   i_draw_value,
    input  logic [lsta_pkg::CORE_W-1:0]  i_core_tag,
    input  logic                         i_stall,
    output logic                         o_valid,
    output logic [2:0]                   o_status,
    output logic [lsta_pkg::ID_W-1:0]    o_winner_id,
    output logic [lsta_pkg::CORE_W-1:0]  o_winner_core,
    output logic [lsta_pkg::SUM_W-1:0]   o_ticket_sum
);
    import lsta_pkg::*;

    localparam int L     = $clog2(SLOTS);
    localparam int CAP   = 1 << L;
    localparam int NODES = 2 * CAP;

    logic [SUM_W-1:0]  m_tree [NODES];
    logic [ID_W:0]     m_slot [CAP];

    // latched command word
    t_op               r_op;
    logic [ID_W-1:0]   r_id;
    logic [TKT_W-1:0]  r_tkt;
    logic [SUM_W-1:0]  r_draw;
    logic [CORE_W-1:0] r_core;

    logic [L:0]        r_clr;
    logic [L:0]        r_count;
    logic [SUM_W-1:0]  r_total;

    // scan state
    logic [L:0]        r_scan_addr;
    logic              r_chk_valid;
    logic [L-1:0]      r_chk_addr;
    logic              r_found, r_free_ok;
    logic [L-1:0]      r_hit_slot, r_free_slot;

    // walk state
    logic [L:0]        r_node;
    logic [SUM_W-1:0]  r_cur;
    logic [SUM_W-1:0]  r_rem;
    logic [SUM_W-1:0]  r_tree_q;
    logic [ID_W:0]     r_slot_q;
    logic [ID_W-1:0]   r_win_id;
    logic [CORE_W-1:0] r_win_core;

    logic              r_out_valid;
    logic [2:0]        r_o_status;
    logic [ID_W-1:0]   r_o_win;
    logic [CORE_W-1:0] r_o_core;
    logic [SUM_W-1:0]  r_o_total;

    logic              tree_we;
    logic [L:0]        tree_waddr, tree_raddr;
    logic [SUM_W-1:0]  tree_wdata;
    logic              slot_we;
    logic [L-1:0]      slot_waddr, slot_raddr;
    logic [ID_W:0]     slot_wdata;
    logic [L-1:0]      leaf_slot;
    logic [SUM_W-1:0]  leaf_val;
    logic [SUM_W:0]    up_sum;
    logic [SUM_W-1:0]  up_sat;
    logic              draw_ok;

    assign leaf_slot = (r_op == OP_ADD) ? r_free_slot : r_hit_slot;
    assign leaf_val  = (r_op == OP_REMOVE) ? '0 : SUM_W'(r_tkt);
    assign up_sum    = {1'b0, r_cur} + {1'b0, r_tree_q};
    assign up_sat    = up_sum[SUM_W] ? {SUM_W{1'b1}} : up_sum[SUM_W-1:0];
    assign draw_ok   = (i_ctl.code == ST_OK) && (r_op == OP_DRAW);

    always_comb begin
        tree_we    = 1'b0;
        tree_waddr = r_clr;
        tree_wdata = '0;
        if (i_ctl.clr) begin
            tree_we = 1'b1;
        end else if (i_ctl.commit && r_op != OP_DRAW) begin
            tree_we    = 1'b1;
            tree_waddr = {1'b1, leaf_slot};
            tree_wdata = leaf_val;
        end else if (i_ctl.up_wr) begin
            tree_we    = 1'b1;
            tree_waddr = {1'b0, r_node[L:1]};
            tree_wdata = up_sat;
        end
    end

    // sibling on the way up, left child on the way down
    assign tree_raddr = i_ctl.up_rd ? (r_node ^ (L+1)'(1)) : {r_node[L-1:0], 1'b0};

    always_comb begin
        slot_we    = 1'b0;
        slot_waddr = r_clr[L-1:0];
        slot_wdata = '0;
        if (i_ctl.clr) begin
            slot_we = 1'b1;
        end else if (i_ctl.commit && (r_op == OP_ADD || r_op == OP_REMOVE)) begin
            slot_we    = 1'b1;
            slot_waddr = leaf_slot;
            slot_wdata = {(r_op == OP_ADD), r_id};
        end
    end

    assign slot_raddr = i_ctl.win_rd ? r_node[L-1:0] : r_scan_addr[L-1:0];

    always_ff @(posedge i_clk) begin
        if (tree_we) m_tree[tree_waddr] <= tree_wdata;
        r_tree_q <= m_tree[tree_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (slot_we) m_slot[slot_waddr] <= slot_wdata;
        r_slot_q <= m_slot[slot_raddr];
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_op   <= t_op'(i_cmd);
            r_id   <= i_client_id;
            r_tkt  <= i_ticket_count;
            r_draw <= i_draw_value;
            r_core <= i_core_tag;
        end
        if (i_ctl.start) begin
            r_found     <= 1'b0;
            r_free_ok   <= 1'b0;
            r_chk_valid <= 1'b0;
        end else if (i_ctl.scan) begin
            r_chk_valid <= !r_scan_addr[L];
            r_chk_addr  <= r_scan_addr[L-1:0];
            if (r_chk_valid && r_slot_q[ID_W] && r_slot_q[ID_W-1:0] == r_id && !r_found) begin
                r_found    <= 1'b1;
                r_hit_slot <= r_chk_addr;
            end
            if (r_chk_valid && !r_slot_q[ID_W] && !r_free_ok) begin
                r_free_ok   <= 1'b1;
                r_free_slot <= r_chk_addr;
            end
        end
        if (i_ctl.commit) begin
            if (r_op == OP_DRAW) begin
                r_node <= (L+1)'(1);
                r_rem  <= r_draw;
            end else begin
                r_node <= {1'b1, leaf_slot};
                r_cur  <= leaf_val;
            end
        end else if (i_ctl.up_wr) begin
            r_node <= {1'b0, r_node[L:1]};
            r_cur  <= up_sat;
        end else if (i_ctl.dn_step) begin
            if (r_rem < r_tree_q) begin
                r_node <= {r_node[L-1:0], 1'b0};
            end else begin
                r_rem  <= r_rem - r_tree_q;
                r_node <= {r_node[L-1:0], 1'b1};
            end
        end
        if (i_ctl.win_ld) begin
            r_win_id   <= r_slot_q[ID_W] ? r_slot_q[ID_W-1:0] : '0;
            r_win_core <= r_core;
        end
        if (i_ctl.out_ld) begin
            r_o_status <= i_ctl.code;
            r_o_win    <= draw_ok ? r_win_id : '0;
            r_o_core   <= draw_ok ? r_win_core : '0;
            r_o_total  <= r_total;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr       <= '0;
            r_count     <= '0;
            r_total     <= '0;
            r_scan_addr <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_ctl.clr) r_clr <= r_clr + (L+1)'(1);
            if (i_ctl.start) begin
                r_scan_addr <= '0;
            end else if (i_ctl.scan && !r_scan_addr[L]) begin
                r_scan_addr <= r_scan_addr + (L+1)'(1);
            end
            if (i_ctl.commit && r_op == OP_ADD) begin
                r_count <= r_count + (L+1)'(1);
            end else if (i_ctl.commit && r_op == OP_REMOVE && r_count != '0) begin
                r_count <= r_count - (L+1)'(1);
            end
            // parent is node one, the root
            if (i_ctl.up_wr && r_node[L:1] == L'(1)) r_total <= up_sat;
            if (i_ctl.out_ld) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_sts           = '0;
        o_sts.clr_done  = &r_clr;
        o_sts.scan_done = r_scan_addr[L] && !r_chk_valid;
        o_sts.found     = r_found;
        o_sts.free_ok   = r_free_ok;
        o_sts.tkt_zero  = (r_tkt == '0);
        o_sts.cnt_zero  = (r_count == '0);
        o_sts.cnt_full  = r_count[L];
        o_sts.draw_big  = (r_draw >= r_total);
        o_sts.at_root   = (r_node == (L+1)'(1));
        o_sts.at_leaf   = r_node[L];
        o_sts.out_free  = !r_out_valid || !i_stall;
        o_sts.op        = r_op;
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_o_status;
    assign o_winner_id   = r_o_win;
    assign o_winner_core = r_o_core;
    assign o_ticket_sum  = r_o_total;

endmodule
